// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned ChainWords = 8;
  localparam int unsigned Rounds     = 64;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;

  typedef logic [ChainWords-1:0][31:0] chain_t;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic start;  // compress the buffered block
    logic init;   // load the initial hash values
  } core_ctl_t;

  // Status from the compression core.
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  localparam logic [31:0] InitHash [ChainWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== src/sha_blkbuf.sv =====
// ----------------------------------------------------------------------------
// sha_blkbuf
// 64-byte message block buffer: 16 x 32-bit words, byte writes, one
// registered read port.
// ----------------------------------------------------------------------------
module sha_blkbuf
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_pos_i,   // byte position, 0 is the first byte
  input  logic [7:0]  wr_data_i,
  input  logic [3:0]  rd_addr_i,
  output logic [31:0] rd_data_o
);

  logic [31:0] mem_q [BlockWords];
  logic [1:0]  lane;

  // big-endian: byte 0 of a word is its top lane
  assign lane = ~wr_pos_i[1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_pos_i[5:2]][{lane, 3'b000} +: 8] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== src/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// SHA-256 compression, one round per cycle. Message words 0..15 are read
// from the block buffer; later words come from a 16-word schedule window.
// ----------------------------------------------------------------------------
module sha_core
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  core_ctl_t   ctl_i,
  output logic [3:0]  rd_addr_o,
  input  logic [31:0] rd_data_i,
  output core_sts_t   sts_o,
  output chain_t      chain_o
);

  typedef enum logic [3:0] {
    CIdle  = 4'b0001,
    CLoad  = 4'b0010,
    CRound = 4'b0100,
    CFinal = 4'b1000
  } core_state_e;

  core_state_e state_q, state_d;
  logic [5:0]  rnd_q;
  chain_t      chain_q;
  logic [31:0] v_q [ChainWords];
  logic [31:0] w_q [BlockWords];
  logic [31:0] w_t, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    if (rnd_q[5:4] == 2'b00) begin
      w_t = rd_data_i;
    end else begin
      w_t = w_q[0] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
          + w_q[9] + (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
    end
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_t;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // word 0 is fetched in the load cycle, word t+1 during round t
  assign rd_addr_o = (state_q == CLoad) ? 4'd0 : rnd_q[3:0] + 4'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CIdle:  if (ctl_i.start) state_d = CLoad;
      CLoad:  state_d = CRound;
      CRound: if (rnd_q == 6'(Rounds - 1)) state_d = CFinal;
      CFinal: state_d = CIdle;
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      rnd_q   <= '0;
      for (int i = 0; i < ChainWords; i++) chain_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      if (state_q == CLoad) begin
        rnd_q <= '0;
      end else if (state_q == CRound) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (ctl_i.init) begin
        for (int i = 0; i < ChainWords; i++) chain_q[i] <= InitHash[i];
      end else if (state_q == CFinal) begin
        for (int i = 0; i < ChainWords; i++) chain_q[i] <= chain_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CLoad) begin
      for (int i = 0; i < ChainWords; i++) v_q[i] <= chain_q[i];
    end else if (state_q == CRound) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i + 1];
      w_q[BlockWords-1] <= w_t;
    end
  end

  assign sts_o.busy = (state_q != CIdle);
  assign sts_o.done = (state_q == CFinal);
  assign chain_o    = chain_q;

endmodule

// ===== src/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest returned as four 64-bit words.
// ----------------------------------------------------------------------------
// One request carries at most one message byte and may end the message. A
// byte is written into the block buffer memory when it is taken; the
// 64th byte of a block starts a compression (a load step, 64 rounds at
// one round per cycle through the shared round logic, a final step to
// fold the result into the chaining words), during which no request is
// taken. End of message triggers padding, written into the buffer one byte
// per cycle (p = 9 to 72 bytes, so one or two more compressions), after which
// the four digest words are offered, most significant first, one per cycle
// while the consumer takes them. The core holds the running chaining words;
// the message length counts bytes modulo 2^61. After the last digest word is
// taken the block is ready for a new message.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,   // taking requests
    StPad  = 4'b0010,   // writing padding bytes
    StComp = 4'b0100,   // compression running
    StOut  = 4'b1000    // offering digest words
  } top_state_e;

  top_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;       // bytes in the buffer
  logic [60:0] msg_q, msg_d;         // message length in bytes
  logic        pad_q, pad_d;         // end of message seen, padding due
  logic        mark_q, mark_d;       // 0x80 marker written
  logic        len_q, len_d;         // writing the length field
  logic [1:0]  idx_q, idx_d;

  logic        wr_en;
  logic [7:0]  wr_data;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  core_ctl_t   ctl;
  core_sts_t   sts;
  chain_t      chain;

  logic        in_acc, out_acc, len_now;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [7:0]  pad_byte;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Padding byte: marker first, zeros up to position 56, then the
  // big-endian bit length in positions 56..63.
  assign bit_len = {msg_q, 3'b000};
  assign len_now = len_q || (mark_q && fill_q == LenStart);
  assign len_sel = ~fill_q[2:0];
  always_comb begin
    priority if (!mark_q) begin
      pad_byte = PadMarker;
    end else if (len_now) begin
      pad_byte = bit_len[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    msg_d     = msg_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    len_d     = len_q;
    idx_d     = idx_q;
    wr_en     = 1'b0;
    wr_data   = data_byte_i;
    ctl.start = 1'b0;
    ctl.init  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          pad_d = end_of_message_i;
          if (byte_valid_i) begin
            wr_en  = 1'b1;
            fill_d = fill_q + 6'd1;
            msg_d  = msg_q + 61'd1;
          end
          priority if (byte_valid_i && fill_q == 6'd63) begin
            ctl.start = 1'b1;
            state_d   = StComp;
          end else if (end_of_message_i) begin
            state_d = StPad;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StPad: begin
        wr_en   = 1'b1;
        wr_data = pad_byte;
        fill_d  = fill_q + 6'd1;
        mark_d  = 1'b1;
        if (len_now) len_d = 1'b1;
        if (fill_q == 6'd63) begin
          ctl.start = 1'b1;
          state_d   = StComp;
        end
      end
      StComp: begin
        if (sts.done) begin
          priority if (len_q) state_d = StOut;
          else if (pad_q)     state_d = StPad;
          else                state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            ctl.init = 1'b1;
            fill_d   = '0;
            msg_d    = '0;
            pad_d    = 1'b0;
            mark_d   = 1'b0;
            len_d    = 1'b0;
            state_d  = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      msg_q   <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      msg_q   <= msg_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  sha_blkbuf u_blkbuf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_pos_i  (fill_q),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .sts_o     (sts),
    .chain_o   (chain)
  );

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = {chain[{idx_q, 1'b0}], chain[{idx_q, 1'b1}]};
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 2'd3);

`ifndef NO_ASSERTIONS
  // The core only runs while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> state_q == StComp)
    else $error("core busy outside compression state");

  // Finishing a digest leaves a clean message state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_word_o |=> fill_q == 6'd0 && msg_q == 61'd0 && !pad_q)
    else $error("message state not cleared after digest");

  // The length field occupies the last eight bytes of the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPad && len_q |-> fill_q >= LenStart)
    else $error("length field written below byte 56");

  // Digest words are only offered once padding completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> len_q && mark_q)
    else $error("digest offered before padding finished");
`endif

endmodule

// ===== bench/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking bench for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
// A short directed table comes first: the empty message, "abc", extreme
// bytes, ignored bytes and back-to-back messages. Random messages follow,
// with lengths that mostly stay short but often land on the padding
// boundaries. A bit-exact SHA-256 model in the bench predicts every digest
// word not typed into the table. Both the request and the digest side stall at random.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 480;
  localparam int unsigned DrainWait  = 300;   // > two compressions plus padding
  localparam int unsigned MaxReports = 10;

  // SHA-256 round constants and initial hash values, kept locally so the
  // model does not lean on the RTL's own tables.
  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Well-known digests, used where the table types the answer in.
  localparam logic [255:0] EmptyDigest =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  // Message lengths right at the padding and block edges: 55 still fits the
  // length field, 56 spills into an extra block, 64/128 fill blocks exactly.
  localparam int unsigned EdgeLens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_part_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         byte_valid;
    logic         end_msg;
    logic         known;    // digest typed in below instead of predicted
    logic [255:0] digest;
  } stim_row_t;

  localparam int unsigned DirRows = 17;

  // Directed requests. Rows with known = 1 carry the expected digest.
  localparam stim_row_t DirTable [DirRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message right after reset
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},    // last byte and end together
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},       // lowest byte
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},       // highest byte
    '{8'haa, 1'b0, 1'b0, 1'b0, 256'h0},       // ignored byte
    '{8'h55, 1'b0, 1'b1, 1'b0, 256'h0},       // empty end marker, data ignored
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},       // one-byte message
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty again, straight after a finish
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hfe, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  logic        clk_i;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i      = 8'h00;
  logic        byte_valid_i     = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [63:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  // Model state: running hash, partial block, message length in bytes.
  logic [31:0] hash_chain [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_count;
  logic [60:0] msg_len;

  digest_part_t digest_q [$];

  logic        calm = 1'b0;   // suppresses all stalls during a stretch
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int unsigned messages_sent = 0;
  int unsigned bytes_sent = 0;

  sha256_stream_hasher i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .byte_valid_i,
    .end_of_message_i,
    .out_valid_o,
    .out_ready_i,
    .digest_word_o,
    .word_index_o,
    .last_word_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // SHA-256 model
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ShaK[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
  endfunction

  function automatic void absorb_byte(logic [7:0] value);
    block_bytes[block_count] = value;
    block_count++;
    if (block_count == 64) begin
      compress_block();
      block_count = 0;
    end
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_chain[i] = ShaIv[i];
    block_count = 0;
    msg_len = '0;
  endfunction

  // Applies one accepted request; on end of message queues the four digest
  // words, either from the model or from a typed-in digest.
  function automatic void predict_request(logic [7:0] data, logic byte_valid, logic end_msg,
                                          logic known, logic [255:0] known_digest);
    logic [63:0] bit_len;
    if (byte_valid) begin
      absorb_byte(data);
      msg_len++;  // wraps at 2^61 like the length field
    end
    if (!end_msg) return;
    bit_len = {msg_len, 3'b000};
    absorb_byte(8'h80);
    while (block_count != 56) absorb_byte(8'h00);
    for (int k = 7; k >= 0; k--) absorb_byte(bit_len[8*k +: 8]);
    for (int k = 0; k < 4; k++) begin
      digest_q.push_back('{
        word:  known ? known_digest[255 - 64*k -: 64]
                     : {hash_chain[2*k], hash_chain[2*k+1]},
        index: 2'(k),
        last:  (k == 3)
      });
    end
    restart_message();
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Valid is left high after an accept; it only drops when a gap is chosen
  // for the next request, so a step never sees two assignments to it.
  task automatic send_request(input logic [7:0] data, input logic byte_valid,
                              input logic end_msg, input logic known,
                              input logic [255:0] known_digest);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= data;
    byte_valid_i     <= byte_valid;
    end_of_message_i <= end_msg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(data, byte_valid, end_msg, known, known_digest);
    if (byte_valid) bytes_sent++;
    if (end_msg) messages_sent++;
  endtask

  // One random message: mostly real bytes, a few ignored bytes mixed in,
  // ended either on the last byte or by an empty end marker.
  task automatic send_message(input int unsigned length, inout int unsigned counted);
    logic tail_marker;
    tail_marker = (length == 0) || $urandom_range(1);
    for (int unsigned i = 0; i < length; i++) begin
      if ($urandom_range(99) < 5) begin
        send_request(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        counted++;
      end
      send_request(8'($urandom), 1'b1, !tail_marker && (i == length - 1), 1'b0, '0);
      counted++;
    end
    if (tail_marker) begin
      send_request(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
      counted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Digest side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 7);
  end

  function automatic void check_word(digest_part_t got);
    digest_part_t want;
    if (digest_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("unexpected digest word %h index %0d last %0b",
                 got.word, got.index, got.last);
      end
      return;
    end
    want = digest_q.pop_front();
    if (got.word !== want.word || got.index !== want.index || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("digest mismatch: word %h/%h index %0d/%0d last %0b/%0b (expected/actual)",
                 want.word, got.word, want.index, got.index, want.last, got.last);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_word({digest_word_o, word_index_o, last_word_o});
      words_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycle_count, digest_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned counted;
    int unsigned msg_no;
    int unsigned length;
    int unsigned wait_cycles;

    restart_message();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    counted = 0;
    msg_no = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      send_request(DirTable[r].data, DirTable[r].byte_valid, DirTable[r].end_msg,
                   DirTable[r].known, DirTable[r].digest);
    end

    // Random messages. Most are short; some sit on block edges, some span
    // two full blocks. Messages 6 to 9 run with no stalls on either side.
    while (counted < RandItems) begin
      calm <= (msg_no >= 6 && msg_no < 10);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: length = $urandom_range(20);
        6, 7:             length = EdgeLens[$urandom_range(9)];
        8:                length = $urandom_range(130, 21);
        default:          length = 0;
      endcase
      send_message(length, counted);
      msg_no++;
    end
    in_valid_i <= 1'b0;
    calm <= 1'b0;

    // Every digest word must arrive, then a quiet spell catches strays.
    while (digest_q.size() != 0) @(posedge clk_i);
    wait_cycles = DrainWait;
    repeat (wait_cycles) @(posedge clk_i);

    $display("hashed %0d messages (%0d bytes), checked %0d digest words",
             messages_sent, bytes_sent, words_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
